// ===== src/segment_corner_tracker_defines.svh =====
// assertion macros for the segment corner tracker checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef SEGMENT_CORNER_TRACKER_DEFINES_SVH
`define SEGMENT_CORNER_TRACKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SCT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segment corner tracker check failed");

// next-cycle implication, disabled during reset
`define SCT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segment corner tracker check failed");

`endif

// ===== src/sct_pkg.sv =====
// shared constants, register codes and types of the segment corner tracker
// no dependencies
package sct_pkg;

    localparam int SEG_BITS        = 12;
    localparam int OUT_BITS        = 13;
    localparam int CFG_DIM_BITS    = 13;
    localparam int CFG_TOL_BITS    = 8;
    localparam int SQ_BITS         = 2 * SEG_BITS;
    localparam int DIST_BITS       = SQ_BITS + 1;
    localparam int SPAN_BITS       = SEG_BITS + 2;
    localparam int COORD_BITS_DEF  = 13;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int SENTINEL_FAR    = 5000;
    localparam int CFG_COLS_RESET  = 640;
    localparam int CFG_ROWS_RESET  = 480;
    localparam int CFG_TOL_RESET   = 15;
    localparam int APB_DATA_BITS   = 32;
    localparam int APB_ADDR_BITS   = 4;
    localparam int REG_IDX_BITS    = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_COLS   = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_ROWS   = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_STRAIGHT_TOL = 2'd2;

    localparam int NUM_CORNERS   = 4;
    localparam int CORNER_TL     = 0;
    localparam int CORNER_TR     = 1;
    localparam int CORNER_BL     = 2;
    localparam int CORNER_BR     = 3;

    typedef struct packed {
        logic [CFG_DIM_BITS-1:0] cols;
        logic [CFG_DIM_BITS-1:0] rows;
        logic [CFG_TOL_BITS-1:0] tol;
    } t_cfg;

    typedef struct packed {
        logic                frame_start;
        logic [SEG_BITS-1:0] x1;
        logic [SEG_BITS-1:0] y1;
        logic [SEG_BITS-1:0] x2;
        logic [SEG_BITS-1:0] y2;
        logic                upd_left;
        logic                upd_right;
        logic                upd_top;
        logic                upd_bottom;
    } t_seg_cmd;

endpackage

// ===== src/sct_seg_if.sv =====
// segment input channel: valid/ready handshake with endpoint payload
// depends on sct_pkg for field widths
interface sct_seg_if;
    logic                         valid;
    logic                         ready;
    logic                         frame_start;
    logic [sct_pkg::SEG_BITS-1:0] seg_x_start;
    logic [sct_pkg::SEG_BITS-1:0] seg_y_start;
    logic [sct_pkg::SEG_BITS-1:0] seg_x_end;
    logic [sct_pkg::SEG_BITS-1:0] seg_y_end;

    modport source (output valid, frame_start, seg_x_start, seg_y_start, seg_x_end, seg_y_end,
                    input ready);
    modport sink   (input valid, frame_start, seg_x_start, seg_y_start, seg_x_end, seg_y_end,
                    output ready);
endinterface

// ===== src/sct_res_if.sv =====
// result channel: valid/ready handshake with corner and center payload
// depends on sct_pkg for field widths
interface sct_res_if;
    logic                         valid;
    logic                         ready;
    logic [sct_pkg::OUT_BITS-1:0] top_left_x;
    logic [sct_pkg::OUT_BITS-1:0] top_left_y;
    logic [sct_pkg::OUT_BITS-1:0] top_right_x;
    logic [sct_pkg::OUT_BITS-1:0] top_right_y;
    logic [sct_pkg::OUT_BITS-1:0] bottom_left_x;
    logic [sct_pkg::OUT_BITS-1:0] bottom_left_y;
    logic [sct_pkg::OUT_BITS-1:0] bottom_right_x;
    logic [sct_pkg::OUT_BITS-1:0] bottom_right_y;
    logic [sct_pkg::OUT_BITS-1:0] center_x;
    logic [sct_pkg::OUT_BITS-1:0] center_y;

    modport source (output valid, top_left_x, top_left_y, top_right_x, top_right_y,
                    bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y,
                    center_x, center_y,
                    input ready);
    modport sink   (input valid, top_left_x, top_left_y, top_right_x, top_right_y,
                    bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y,
                    center_x, center_y,
                    output ready);
endinterface

// ===== src/sct_front.sv =====
// front end: accepts segments, orders endpoints by squared distance, classifies edges
// depends on sct_pkg and sct_seg_if
module sct_front #(
    parameter int QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sct_pkg::t_cfg     i_cfg,
    input  logic              i_pop,
    sct_seg_if.sink           i_seg,
    output logic              o_push,
    output sct_pkg::t_seg_cmd o_cmd
);
    import sct_pkg::*;

    localparam int CREDIT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CREDIT_W-1:0]  r_credit, n_credit;
    logic                 w_accept;

    // stage a: raw endpoints and their squares
    logic                 r_a_valid;
    logic                 r_a_frame;
    logic [SEG_BITS-1:0]  r_a_x1, r_a_y1, r_a_x2, r_a_y2;
    logic [SQ_BITS-1:0]   r_a_xx1, r_a_yy1, r_a_xx2, r_a_yy2;

    logic [DIST_BITS-1:0] w_d1, w_d2;
    logic                 w_swap;
    logic [SEG_BITS-1:0]  w_x1, w_y1, w_x2, w_y2;
    logic [SEG_BITS-1:0]  w_half_c, w_half_r;
    logic signed [SPAN_BITS-1:0] w_dx, w_dy, w_half_c_s, w_half_r_s;
    logic [SPAN_BITS-1:0] w_adx, w_ady;
    logic                 w_long, w_vert, w_horz;

    // credits cover every item between acceptance and the back end's pop
    assign i_seg.ready = (r_credit < CREDIT_W'(QUEUE_DEPTH));
    assign w_accept    = i_seg.valid && i_seg.ready;

    always_comb begin
        n_credit = r_credit;
        if (w_accept && !i_pop) begin
            n_credit = r_credit + 1'b1;
        end else if (!w_accept && i_pop) begin
            n_credit = r_credit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit  <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_credit  <= n_credit;
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_frame <= i_seg.frame_start;
            r_a_x1    <= i_seg.seg_x_start;
            r_a_y1    <= i_seg.seg_y_start;
            r_a_x2    <= i_seg.seg_x_end;
            r_a_y2    <= i_seg.seg_y_end;
            r_a_xx1   <= SQ_BITS'(i_seg.seg_x_start) * SQ_BITS'(i_seg.seg_x_start);
            r_a_yy1   <= SQ_BITS'(i_seg.seg_y_start) * SQ_BITS'(i_seg.seg_y_start);
            r_a_xx2   <= SQ_BITS'(i_seg.seg_x_end) * SQ_BITS'(i_seg.seg_x_end);
            r_a_yy2   <= SQ_BITS'(i_seg.seg_y_end) * SQ_BITS'(i_seg.seg_y_end);
        end
    end

    // stage b: order endpoints, length test, orientation and side
    always_comb begin
        w_d1   = {1'b0, r_a_xx1} + {1'b0, r_a_yy1};
        w_d2   = {1'b0, r_a_xx2} + {1'b0, r_a_yy2};
        w_swap = (w_d1 > w_d2);
        w_x1   = w_swap ? r_a_x2 : r_a_x1;
        w_y1   = w_swap ? r_a_y2 : r_a_y1;
        w_x2   = w_swap ? r_a_x1 : r_a_x2;
        w_y2   = w_swap ? r_a_y1 : r_a_y2;

        w_half_c   = i_cfg.cols[CFG_DIM_BITS-1:1];
        w_half_r   = i_cfg.rows[CFG_DIM_BITS-1:1];
        w_half_c_s = $signed({2'b00, w_half_c});
        w_half_r_s = $signed({2'b00, w_half_r});

        w_dx  = $signed({2'b00, w_x2}) - $signed({2'b00, w_x1});
        w_dy  = $signed({2'b00, w_y2}) - $signed({2'b00, w_y1});
        w_adx = w_dx[SPAN_BITS-1] ? SPAN_BITS'(-w_dx) : SPAN_BITS'(w_dx);
        w_ady = w_dy[SPAN_BITS-1] ? SPAN_BITS'(-w_dy) : SPAN_BITS'(w_dy);

        w_long = (w_dx >= w_half_c_s) || (w_dy >= w_half_r_s);
        w_vert = (w_adx <= SPAN_BITS'(i_cfg.tol));
        w_horz = (w_ady <= SPAN_BITS'(i_cfg.tol));

        o_cmd.frame_start = r_a_frame;
        o_cmd.x1          = w_x1;
        o_cmd.y1          = w_y1;
        o_cmd.x2          = w_x2;
        o_cmd.y2          = w_y2;
        o_cmd.upd_left    = w_long && w_vert && (w_x1 < w_half_c);
        o_cmd.upd_right   = w_long && w_vert && (w_x1 > w_half_c);
        o_cmd.upd_top     = w_long && w_horz && (w_y1 < w_half_r);
        o_cmd.upd_bottom  = w_long && w_horz && (w_y1 > w_half_r);
    end

    assign o_push = r_a_valid;

endmodule

// ===== src/sct_queue.sv =====
// short queue of classified segment commands between front and back
// depends on sct_pkg
module sct_queue #(
    parameter int DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sct_pkg::t_seg_cmd i_cmd,
    input  logic              i_pop,
    output sct_pkg::t_seg_cmd o_cmd,
    output logic              o_empty
);
    import sct_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_seg_cmd         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/sct_back.sv =====
// back end: corner min/max update, center point and the result register
// depends on sct_pkg and sct_res_if
module sct_back #(
    parameter int COORD_BITS = sct_pkg::COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  sct_pkg::t_seg_cmd i_cmd,
    output logic              o_pop,
    sct_res_if.source         o_res
);
    import sct_pkg::*;

    localparam logic [COORD_BITS-1:0] SENT = COORD_BITS'(SENTINEL_FAR);

    logic [COORD_BITS-1:0] r_cx [NUM_CORNERS];
    logic [COORD_BITS-1:0] r_cy [NUM_CORNERS];
    logic [COORD_BITS-1:0] n_cx [NUM_CORNERS];
    logic [COORD_BITS-1:0] n_cy [NUM_CORNERS];
    logic [COORD_BITS-1:0] w_x1, w_y1, w_x2, w_y2;
    logic [COORD_BITS:0]   w_st_x, w_st_y, w_sb_x, w_sb_y, w_sc_x, w_sc_y;
    logic [COORD_BITS-1:0] w_mt_x, w_mt_y, w_mb_x, w_mb_y;

    logic                  r_valid;
    logic [OUT_BITS-1:0]   r_ox [NUM_CORNERS];
    logic [OUT_BITS-1:0]   r_oy [NUM_CORNERS];
    logic [OUT_BITS-1:0]   r_ocx, r_ocy;

    assign o_pop = !i_empty && (!r_valid || o_res.ready);

    always_comb begin
        w_x1 = COORD_BITS'(i_cmd.x1);
        w_y1 = COORD_BITS'(i_cmd.y1);
        w_x2 = COORD_BITS'(i_cmd.x2);
        w_y2 = COORD_BITS'(i_cmd.y2);

        // frame start restarts from the sentinels
        if (i_cmd.frame_start) begin
            n_cx[CORNER_TL] = SENT;  n_cy[CORNER_TL] = SENT;
            n_cx[CORNER_TR] = '0;    n_cy[CORNER_TR] = SENT;
            n_cx[CORNER_BL] = SENT;  n_cy[CORNER_BL] = '0;
            n_cx[CORNER_BR] = '0;    n_cy[CORNER_BR] = '0;
        end else begin
            n_cx = r_cx;
            n_cy = r_cy;
        end

        if (i_cmd.upd_left) begin
            if (w_x1 < n_cx[CORNER_TL]) n_cx[CORNER_TL] = w_x1;
            if (w_x2 < n_cx[CORNER_BL]) n_cx[CORNER_BL] = w_x2;
        end
        if (i_cmd.upd_right) begin
            if (w_x1 > n_cx[CORNER_TR]) n_cx[CORNER_TR] = w_x1;
            if (w_x2 > n_cx[CORNER_BR]) n_cx[CORNER_BR] = w_x2;
        end
        if (i_cmd.upd_top) begin
            if (w_x1 < n_cx[CORNER_TL]) n_cx[CORNER_TL] = w_x1;
            if (w_y1 < n_cy[CORNER_TL]) n_cy[CORNER_TL] = w_y1;
            if (w_x2 > n_cx[CORNER_TR]) n_cx[CORNER_TR] = w_x2;
            if (w_y2 < n_cy[CORNER_TR]) n_cy[CORNER_TR] = w_y2;
        end
        if (i_cmd.upd_bottom) begin
            if (w_x1 < n_cx[CORNER_BL]) n_cx[CORNER_BL] = w_x1;
            if (w_y1 > n_cy[CORNER_BL]) n_cy[CORNER_BL] = w_y1;
            if (w_x2 > n_cx[CORNER_BR]) n_cx[CORNER_BR] = w_x2;
            if (w_y2 > n_cy[CORNER_BR]) n_cy[CORNER_BR] = w_y2;
        end

        // floored midpoints of top and bottom edges, then their average
        w_st_x = {1'b0, n_cx[CORNER_TL]} + {1'b0, n_cx[CORNER_TR]};
        w_st_y = {1'b0, n_cy[CORNER_TL]} + {1'b0, n_cy[CORNER_TR]};
        w_sb_x = {1'b0, n_cx[CORNER_BL]} + {1'b0, n_cx[CORNER_BR]};
        w_sb_y = {1'b0, n_cy[CORNER_BL]} + {1'b0, n_cy[CORNER_BR]};
        w_mt_x = w_st_x[COORD_BITS:1];
        w_mt_y = w_st_y[COORD_BITS:1];
        w_mb_x = w_sb_x[COORD_BITS:1];
        w_mb_y = w_sb_y[COORD_BITS:1];
        w_sc_x = {1'b0, w_mt_x} + {1'b0, w_mb_x};
        w_sc_y = {1'b0, w_mt_y} + {1'b0, w_mb_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= 1'b0;
            r_cx[CORNER_TL] <= SENT;  r_cy[CORNER_TL] <= SENT;
            r_cx[CORNER_TR] <= '0;    r_cy[CORNER_TR] <= SENT;
            r_cx[CORNER_BL] <= SENT;  r_cy[CORNER_BL] <= '0;
            r_cx[CORNER_BR] <= '0;    r_cy[CORNER_BR] <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_cx    <= n_cx;
                r_cy    <= n_cy;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                r_ox[i] <= n_cx[i][OUT_BITS-1:0];
                r_oy[i] <= n_cy[i][OUT_BITS-1:0];
            end
            r_ocx <= w_sc_x[OUT_BITS:1];
            r_ocy <= w_sc_y[OUT_BITS:1];
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.top_left_x     = r_ox[CORNER_TL];
    assign o_res.top_left_y     = r_oy[CORNER_TL];
    assign o_res.top_right_x    = r_ox[CORNER_TR];
    assign o_res.top_right_y    = r_oy[CORNER_TR];
    assign o_res.bottom_left_x  = r_ox[CORNER_BL];
    assign o_res.bottom_left_y  = r_oy[CORNER_BL];
    assign o_res.bottom_right_x = r_ox[CORNER_BR];
    assign o_res.bottom_right_y = r_oy[CORNER_BR];
    assign o_res.center_x       = r_ocx;
    assign o_res.center_y       = r_ocy;

endmodule

// ===== src/segment_corner_tracker.sv =====
// an accepted item passes the squaring register, the command queue and the result register
// throughput: one item per cycle; the input stalls only when the command queue
// and the squaring stage hold QUEUE_DEPTH items the back end has not taken
// the back end takes one queued item per cycle while the result register is free or read
// reset (synchronous, active low) empties the pipeline and the queue, restores the
// corner sentinels and loads the register defaults 640, 480 and 15
module segment_corner_tracker #(
    parameter int COORD_BITS  = sct_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sct_seg_if.sink                           i_seg,
    sct_res_if.source                         o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sct_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [sct_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [sct_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import sct_pkg::*;

    // configuration registers
    logic [CFG_DIM_BITS-1:0] r_cols;
    logic [CFG_DIM_BITS-1:0] r_rows;
    logic [CFG_TOL_BITS-1:0] r_tol;
    logic [REG_IDX_BITS-1:0] w_reg_idx;
    logic                    w_cfg_wr;
    t_cfg                    w_cfg;

    // front to queue to back
    logic                    w_push;
    logic                    w_pop;
    logic                    w_empty;
    t_seg_cmd                w_push_cmd;
    t_seg_cmd                w_head_cmd;

    // apb: no wait states, register index from word address
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_DIM_BITS'(CFG_COLS_RESET);
            r_rows <= CFG_DIM_BITS'(CFG_ROWS_RESET);
            r_tol  <= CFG_TOL_BITS'(CFG_TOL_RESET);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_IMAGE_COLS:   r_cols <= pwdata[CFG_DIM_BITS-1:0];
                REG_IMAGE_ROWS:   r_rows <= pwdata[CFG_DIM_BITS-1:0];
                REG_STRAIGHT_TOL: r_tol  <= pwdata[CFG_TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // readback, unused addresses read zero
    always_comb begin
        unique case (w_reg_idx)
            REG_IMAGE_COLS:   prdata = APB_DATA_BITS'(r_cols);
            REG_IMAGE_ROWS:   prdata = APB_DATA_BITS'(r_rows);
            REG_STRAIGHT_TOL: prdata = APB_DATA_BITS'(r_tol);
            default:          prdata = '0;
        endcase
    end

    // user must change registers only while idle, not enforced; front reads them directly
    assign w_cfg.cols = r_cols;
    assign w_cfg.rows = r_rows;
    assign w_cfg.tol  = r_tol;

    // front: squares, endpoint ordering and edge classification
    sct_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_pop   (w_pop),
        .i_seg   (i_seg),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // command queue, sized so the front never overruns it
    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty)
    );

    // back: corner state update and the result register
    sct_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_head_cmd),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

// ===== src/sct_checker.sv =====
// port-level checks of the segment corner tracker and their bind to the top level
// depends on segment_corner_tracker_defines.svh and sct_pkg
`include "segment_corner_tracker_defines.svh"

module sct_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_pready,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic [sct_pkg::OUT_BITS-1:0] i_tl_x,
    input logic [sct_pkg::OUT_BITS-1:0] i_tl_y,
    input logic [sct_pkg::OUT_BITS-1:0] i_tr_x,
    input logic [sct_pkg::OUT_BITS-1:0] i_tr_y,
    input logic [sct_pkg::OUT_BITS-1:0] i_bl_x,
    input logic [sct_pkg::OUT_BITS-1:0] i_bl_y,
    input logic [sct_pkg::OUT_BITS-1:0] i_br_x,
    input logic [sct_pkg::OUT_BITS-1:0] i_br_y,
    input logic [sct_pkg::OUT_BITS-1:0] i_cx,
    input logic [sct_pkg::OUT_BITS-1:0] i_cy
);
    import sct_pkg::*;

    localparam logic [OUT_BITS-1:0] FAR = OUT_BITS'(SENTINEL_FAR);

    // a stalled result keeps its corners and center
    `SCT_ASSERT_NXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_tl_x) && $stable(i_tl_y) && $stable(i_tr_x) && $stable(i_tr_y) && $stable(i_bl_x) && $stable(i_bl_y) && $stable(i_br_x) && $stable(i_br_y) && $stable(i_cx) && $stable(i_cy))

    // corners never leave the box spanned by zero and the sentinel
    `SCT_ASSERT_IMP(a_corner_range, i_res_valid, i_tl_x <= FAR && i_tl_y <= FAR && i_tr_x <= FAR && i_tr_y <= FAR && i_bl_x <= FAR && i_bl_y <= FAR && i_br_x <= FAR && i_br_y <= FAR)

    // center is an average of corners, so it stays in the same box
    `SCT_ASSERT_IMP(a_center_range, i_res_valid, i_cx <= FAR && i_cy <= FAR)

    // configuration port has no wait states
    `SCT_ASSERT_IMP(a_pready_high, 1'b1, i_pready)

endmodule

bind segment_corner_tracker sct_checker u_sct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pready    (pready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_tl_x      (o_res.top_left_x),
    .i_tl_y      (o_res.top_left_y),
    .i_tr_x      (o_res.top_right_x),
    .i_tr_y      (o_res.top_right_y),
    .i_bl_x      (o_res.bottom_left_x),
    .i_bl_y      (o_res.bottom_left_y),
    .i_br_x      (o_res.bottom_right_x),
    .i_br_y      (o_res.bottom_right_y),
    .i_cx        (o_res.center_x),
    .i_cy        (o_res.center_y)
);

// ===== bench/segment_corner_tracker_tb.sv =====
// self-checking bench for the segment corner tracker: random and directed segments,
// a corner predictor and an in-order result scoreboard
// depends on sct_pkg, sct_seg_if, sct_res_if and segment_corner_tracker
module segment_corner_tracker_tb;
    import sct_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with work pending and nothing moving
    localparam int HOLD_AT     = 120;   // result count that triggers the long back-pressure
    localparam int LONG_HOLD   = 64;    // length of that back-pressure in cycles

    typedef struct {
        logic                frame_start;
        logic [SEG_BITS-1:0] x1;
        logic [SEG_BITS-1:0] y1;
        logic [SEG_BITS-1:0] x2;
        logic [SEG_BITS-1:0] y2;
    } t_segment;

    typedef struct {
        int x;
        int y;
    } t_corner_pt;

    typedef struct packed {
        logic [OUT_BITS-1:0] top_left_x;
        logic [OUT_BITS-1:0] top_left_y;
        logic [OUT_BITS-1:0] top_right_x;
        logic [OUT_BITS-1:0] top_right_y;
        logic [OUT_BITS-1:0] bottom_left_x;
        logic [OUT_BITS-1:0] bottom_left_y;
        logic [OUT_BITS-1:0] bottom_right_x;
        logic [OUT_BITS-1:0] bottom_right_y;
        logic [OUT_BITS-1:0] center_x;
        logic [OUT_BITS-1:0] center_y;
    } t_corner_report;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    sct_seg_if seg_bus();
    sct_res_if res_bus();

    segment_corner_tracker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers and the tracked corners
    logic [CFG_DIM_BITS-1:0] cols_cfg;
    logic [CFG_DIM_BITS-1:0] rows_cfg;
    logic [CFG_TOL_BITS-1:0] tol_cfg;
    t_corner_pt              corner_at [NUM_CORNERS];

    t_segment       segment_q [$];  // items waiting for the driver
    t_corner_report report_q [$];   // predicted results, oldest first
    t_segment       on_bus;         // item currently offered on the input channel
    t_corner_report oldest_report;

    int src_idle_pct;
    int sink_idle_pct;
    int mismatch_count;
    int results_seen;
    int hold_cycles;
    bit hold_done;
    int stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void restore_corners();
        corner_at[CORNER_TL] = '{SENTINEL_FAR, SENTINEL_FAR};
        corner_at[CORNER_TR] = '{0, SENTINEL_FAR};
        corner_at[CORNER_BL] = '{SENTINEL_FAR, 0};
        corner_at[CORNER_BR] = '{0, 0};
    endfunction

    function automatic int lesser(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int greater(int a, int b);
        return (a > b) ? a : b;
    endfunction

    // applies one segment to the tracked corners and returns the report it yields
    function automatic t_corner_report track_segment(t_segment s);
        int             x1, y1, x2, y2, tmp;
        int             half_c, half_r, tol, dx, dy;
        int             mtx, mty, mbx, mby;
        bit             vert, horz;
        t_corner_report r;
        x1 = s.x1;
        y1 = s.y1;
        x2 = s.x2;
        y2 = s.y2;
        half_c = cols_cfg >> 1;
        half_r = rows_cfg >> 1;
        tol = tol_cfg;
        if (s.frame_start)
            restore_corners();
        // nearer endpoint first, ties keep their order
        if (x1 * x1 + y1 * y1 > x2 * x2 + y2 * y2) begin
            tmp = x1; x1 = x2; x2 = tmp;
            tmp = y1; y1 = y2; y2 = tmp;
        end
        dx = x2 - x1;
        dy = y2 - y1;
        // only long segments, signed span against the floored half size
        if (dx >= half_c || dy >= half_r) begin
            vert = ((dx < 0) ? -dx : dx) <= tol;
            horz = ((dy < 0) ? -dy : dy) <= tol;
            if (vert && x1 < half_c) begin
                corner_at[CORNER_TL].x = lesser(corner_at[CORNER_TL].x, x1);
                corner_at[CORNER_BL].x = lesser(corner_at[CORNER_BL].x, x2);
            end
            if (vert && x1 > half_c) begin
                corner_at[CORNER_TR].x = greater(corner_at[CORNER_TR].x, x1);
                corner_at[CORNER_BR].x = greater(corner_at[CORNER_BR].x, x2);
            end
            if (horz && y1 < half_r) begin
                corner_at[CORNER_TL].x = lesser(corner_at[CORNER_TL].x, x1);
                corner_at[CORNER_TL].y = lesser(corner_at[CORNER_TL].y, y1);
                corner_at[CORNER_TR].x = greater(corner_at[CORNER_TR].x, x2);
                corner_at[CORNER_TR].y = lesser(corner_at[CORNER_TR].y, y2);
            end
            if (horz && y1 > half_r) begin
                corner_at[CORNER_BL].x = lesser(corner_at[CORNER_BL].x, x1);
                corner_at[CORNER_BL].y = greater(corner_at[CORNER_BL].y, y1);
                corner_at[CORNER_BR].x = greater(corner_at[CORNER_BR].x, x2);
                corner_at[CORNER_BR].y = greater(corner_at[CORNER_BR].y, y2);
            end
        end
        // edge midpoints, then their average, all floored
        mtx = (corner_at[CORNER_TL].x + corner_at[CORNER_TR].x) / 2;
        mty = (corner_at[CORNER_TL].y + corner_at[CORNER_TR].y) / 2;
        mbx = (corner_at[CORNER_BL].x + corner_at[CORNER_BR].x) / 2;
        mby = (corner_at[CORNER_BL].y + corner_at[CORNER_BR].y) / 2;
        r.top_left_x     = OUT_BITS'(corner_at[CORNER_TL].x);
        r.top_left_y     = OUT_BITS'(corner_at[CORNER_TL].y);
        r.top_right_x    = OUT_BITS'(corner_at[CORNER_TR].x);
        r.top_right_y    = OUT_BITS'(corner_at[CORNER_TR].y);
        r.bottom_left_x  = OUT_BITS'(corner_at[CORNER_BL].x);
        r.bottom_left_y  = OUT_BITS'(corner_at[CORNER_BL].y);
        r.bottom_right_x = OUT_BITS'(corner_at[CORNER_BR].x);
        r.bottom_right_y = OUT_BITS'(corner_at[CORNER_BR].y);
        r.center_x       = OUT_BITS'((mtx + mbx) / 2);
        r.center_y       = OUT_BITS'((mty + mby) / 2);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic int clip_coord(int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    function automatic void queue_segment(bit fs, int x1, int y1, int x2, int y2);
        t_segment s;
        s.frame_start = fs;
        s.x1 = SEG_BITS'(x1);
        s.y1 = SEG_BITS'(y1);
        s.x2 = SEG_BITS'(x2);
        s.y2 = SEG_BITS'(y2);
        segment_q.push_back(s);
    endfunction

    // mostly near-straight long segments sized to the current image, some noise
    function automatic void queue_random_segment();
        int  kind, long_half, side_half, span, a, b, side, side2, drift, pick;
        bit  fs;
        kind = $urandom_range(9);
        fs = ($urandom_range(19) == 0);
        if (kind >= 8) begin
            queue_segment(fs, $urandom_range(4095), $urandom_range(4095),
                          $urandom_range(4095), $urandom_range(4095));
        end else begin
            // vertical segments run along y, horizontal ones along x
            long_half = (kind < 4) ? (rows_cfg >> 1) : (cols_cfg >> 1);
            side_half = clip_coord((kind < 4) ? (cols_cfg >> 1) : (rows_cfg >> 1));
            span = long_half + $urandom_range(200);
            if ($urandom_range(7) == 0)
                span = long_half - 1;  // just too short
            span = clip_coord(span);
            a = $urandom_range(4095 - span);
            b = a + span;
            pick = $urandom_range(3);
            if (pick == 0)
                side = side_half;      // exactly on the split
            else if (pick == 1)
                side = $urandom_range(4095);
            else
                side = $urandom_range(clip_coord(2 * side_half));
            drift = int'($urandom_range(2 * tol_cfg + 2)) - int'(tol_cfg) - 1;
            side2 = clip_coord(side + drift);
            if ($urandom_range(1)) begin
                // far endpoint first, exercises the reordering
                if (kind < 4)
                    queue_segment(fs, side2, b, side, a);
                else
                    queue_segment(fs, b, side2, a, side);
            end else begin
                if (kind < 4)
                    queue_segment(fs, side, a, side2, b);
                else
                    queue_segment(fs, a, side, b, side2);
            end
        end
    endfunction

    // write through the register port in setup and access phases, predictor copy follows
    task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [APB_DATA_BITS-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_COLS:   cols_cfg = value[CFG_DIM_BITS-1:0];
            REG_IMAGE_ROWS:   rows_cfg = value[CFG_DIM_BITS-1:0];
            REG_STRAIGHT_TOL: tol_cfg  = value[CFG_TOL_BITS-1:0];
            default: ;
        endcase
    endtask

    // every queued item accepted and every predicted result seen
    task automatic wait_drained();
        do @(negedge i_clk);
        while (segment_q.size() != 0 || seg_bus.valid || report_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic run_phase(int cols, int rows, int tol, int count, int src_pct, int sink_pct);
        wait_drained();
        write_reg(REG_IMAGE_COLS, cols);
        write_reg(REG_IMAGE_ROWS, rows);
        write_reg(REG_STRAIGHT_TOL, tol);
        @(negedge i_clk);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count) queue_random_segment();
    endtask

    function automatic void check_field(string name, logic [OUT_BITS-1:0] want,
                                        logic [OUT_BITS-1:0] got);
        if (want !== got) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // driver: offers queued items, predicts each one as it is taken
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_bus.valid       <= 1'b0;
            seg_bus.frame_start <= 1'b0;
            seg_bus.seg_x_start <= '0;
            seg_bus.seg_y_start <= '0;
            seg_bus.seg_x_end   <= '0;
            seg_bus.seg_y_end   <= '0;
        end else begin
            // item taken at this edge, so its result joins the expected queue
            if (seg_bus.valid && seg_bus.ready)
                report_q.push_back(track_segment(on_bus));
            // load the next item or idle, only when the bus is free
            if (!seg_bus.valid || seg_bus.ready) begin
                if (segment_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    on_bus = segment_q.pop_front();
                    seg_bus.valid       <= 1'b1;
                    seg_bus.frame_start <= on_bus.frame_start;
                    seg_bus.seg_x_start <= on_bus.x1;
                    seg_bus.seg_y_start <= on_bus.y1;
                    seg_bus.seg_x_end   <= on_bus.x2;
                    seg_bus.seg_y_end   <= on_bus.y2;
                end else begin
                    seg_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks each taken result, drives ready with random stalls
    // and one long hold-off that fills the block up
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            hold_cycles   <= 0;
            hold_done     <= 1'b0;
            results_seen  <= 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                results_seen <= results_seen + 1;
                if (report_q.size() == 0) begin
                    $error("result item arrived with no prediction pending");
                    mismatch_count++;
                end else begin
                    oldest_report = report_q.pop_front();
                    check_field("top_left_x", oldest_report.top_left_x, res_bus.top_left_x);
                    check_field("top_left_y", oldest_report.top_left_y, res_bus.top_left_y);
                    check_field("top_right_x", oldest_report.top_right_x, res_bus.top_right_x);
                    check_field("top_right_y", oldest_report.top_right_y, res_bus.top_right_y);
                    check_field("bottom_left_x", oldest_report.bottom_left_x,
                                res_bus.bottom_left_x);
                    check_field("bottom_left_y", oldest_report.bottom_left_y,
                                res_bus.bottom_left_y);
                    check_field("bottom_right_x", oldest_report.bottom_right_x,
                                res_bus.bottom_right_x);
                    check_field("bottom_right_y", oldest_report.bottom_right_y,
                                res_bus.bottom_right_y);
                    check_field("center_x", oldest_report.center_x, res_bus.center_x);
                    check_field("center_y", oldest_report.center_y, res_bus.center_y);
                end
            end
            if (!hold_done && results_seen == HOLD_AT) begin
                // long back-pressure while the sender keeps offering
                hold_done     <= 1'b1;
                hold_cycles   <= LONG_HOLD;
                res_bus.ready <= 1'b0;
            end else if (hold_cycles > 0) begin
                hold_cycles   <= hold_cycles - 1;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // watchdog: only counts while something is still in flight
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((seg_bus.valid && seg_bus.ready) || (res_bus.valid && res_bus.ready)
                     || (segment_q.size() == 0 && !seg_bus.valid && report_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        // known values on every input from time zero
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        seg_bus.valid       = 1'b0;
        seg_bus.frame_start = 1'b0;
        seg_bus.seg_x_start = '0;
        seg_bus.seg_y_start = '0;
        seg_bus.seg_x_end   = '0;
        seg_bus.seg_y_end   = '0;
        res_bus.ready       = 1'b0;
        src_idle_pct        = 11;
        sink_idle_pct       = 45;
        mismatch_count      = 0;
        // predictor starts at the register defaults and the sentinels
        cols_cfg = CFG_COLS_RESET;
        rows_cfg = CFG_ROWS_RESET;
        tol_cfg  = CFG_TOL_RESET;
        restore_corners();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, default image 640 x 480, tolerance 15
        @(negedge i_clk);
        queue_segment(1, 0, 0, 0, 0);              // short, sentinels only
        queue_segment(0, 10, 20, 12, 400);         // left edge
        queue_segment(0, 600, 30, 590, 460);       // right edge
        queue_segment(0, 320, 10, 320, 300);       // vertical on the split, ignored
        queue_segment(0, 15, 25, 620, 30);         // top edge
        queue_segment(0, 20, 450, 630, 455);       // bottom edge
        queue_segment(0, 10, 240, 500, 240);       // horizontal on the split, ignored
        queue_segment(0, 630, 470, 5, 460);        // far endpoint first, swapped
        queue_segment(0, 4095, 0, 0, 4095);        // equal distances keep order
        queue_segment(0, 300, 400, 400, 300);      // equal distances, too short
        queue_segment(0, 0, 0, 4095, 4095);        // extreme diagonal
        queue_segment(1, 4095, 4095, 4095, 4095);  // restart at the far corner
        queue_segment(0, 4095, 0, 4095, 4095);     // right edge at the border
        queue_segment(0, 0, 4095, 4095, 4095);     // bottom edge at the border
        queue_segment(0, 0, 0, 0, 4095);           // left edge at the border
        queue_segment(0, 0, 0, 4095, 0);           // top edge at the border

        // sender idles lightly, receiver heavily
        run_phase(640, 480, 15, 250, 11, 45);
        run_phase(4096, 4096, 255, 150, 11, 45);
        // then the other way round
        run_phase(1, 1, 0, 150, 45, 11);
        run_phase(1920, 1080, 40, 150, 45, 11);
        // zero size: every non-negative span is long enough, no idling from here on
        run_phase(0, 0, 255, 150, 0, 0);
        queue_segment(1, 5, 5, 10, 8);             // passes both tests at once
        queue_segment(0, 0, 0, 3, 2);              // on both splits, ignored
        queue_segment(0, 4095, 4095, 4090, 4000);  // far endpoint first, spans positive after the swap
        run_phase(64, 48, 8, 200, 0, 0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/sct_pkg.sv
src/sct_seg_if.sv
src/sct_res_if.sv
src/sct_front.sv
src/sct_queue.sv
src/sct_back.sv
src/segment_corner_tracker.sv
src/sct_checker.sv
bench/segment_corner_tracker_tb.sv
